FILE: hdl/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/bchpg_pkg.sv
// ----------------------------------------------------------------------------
// bchpg_pkg
// shared widths, reset values and register codes of the bch parity generator
// ----------------------------------------------------------------------------
package bchpg_pkg;

   // default sizes handed to the top level
   localparam int MSG_WIDTH_DEF    = 64;
   localparam int PARITY_WIDTH_DEF = 32;

   // fixed field widths
   localparam int COUNT_W     = 7;
   localparam int DEGREE_W    = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   // largest generator degree the degree register can hold
   localparam int MAX_DEGREE = (1 << DEGREE_W) - 1;

   // division steps folded into one pipeline stage
   localparam int STEPS_PER_STAGE = 8;

   // register reset values: the 21-bit beacon bch code
   localparam logic [CSR_DATA_W-1:0] GEN_POLY_RST = 32'h0026_D9E3;
   localparam logic [DEGREE_W-1:0]   DEGREE_RST   = 5'd21;
   localparam logic [CSR_DATA_W-1:0] REM_MASK_RST = 32'h001F_FFFF;

   // configuration register codes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GEN_POLY = 2'd0,
      CSR_DEGREE   = 2'd1,
      CSR_REM_MASK = 2'd2
   } csr_index_type;

endpackage

FILE: hdl/bchpg_prep.sv
// ----------------------------------------------------------------------------
// bchpg_prep
// front stage: drops message bits above the count and appends the parity
// padding, giving one fixed-length bit stream sent from its top bit down
// ----------------------------------------------------------------------------
module bchpg_prep #(
   parameter int MSG_WIDTH = bchpg_pkg::MSG_WIDTH_DEF,
   parameter int STREAM_W  = MSG_WIDTH + bchpg_pkg::MAX_DEGREE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic [MSG_WIDTH-1:0]             message,
   input  logic [bchpg_pkg::COUNT_W-1:0]    bit_count,
   input  logic [bchpg_pkg::DEGREE_W-1:0]   degree,
   output logic                             out_valid,
   output logic [STREAM_W-1:0]              out_stream
);

   logic [MSG_WIDTH-1:0] used_msg;
   logic [STREAM_W-1:0]  stream_in;
   logic [STREAM_W-1:0]  stream_ff;
   logic                 valid_ff;

   // keep only the low bit_count bits; counts past the width keep all
   always_comb begin
      for (int b = 0; b < MSG_WIDTH; b++) begin
         used_msg[b] = message[b] & (bchpg_pkg::COUNT_W'(b) < bit_count);
      end
   end

   // leading zeros leave the remainder untouched, so the degree zeros go last
   assign stream_in = {{(STREAM_W - MSG_WIDTH){1'b0}}, used_msg} << degree;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stream_ff <= stream_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_stream = stream_ff;

endmodule

FILE: hdl/bchpg_stage.sv
// ----------------------------------------------------------------------------
// bchpg_stage
// one pipeline stage of the division: a fixed slice of stream bits is shifted
// through the remainder register, subtracting the generator on each tap
// ----------------------------------------------------------------------------
module bchpg_stage #(
   parameter int PARITY_WIDTH = bchpg_pkg::PARITY_WIDTH_DEF,
   parameter int STREAM_W     = 96,
   parameter int STAGE_IDX    = 0,
   parameter int STEPS        = bchpg_pkg::STEPS_PER_STAGE
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [STREAM_W-1:0]     in_stream,
   input  logic [PARITY_WIDTH-1:0] in_rem,
   input  logic [PARITY_WIDTH-1:0] poly,
   input  logic [PARITY_WIDTH-1:0] mask,
   input  logic [PARITY_WIDTH-1:0] tap_vec,
   output logic                    out_valid,
   output logic [STREAM_W-1:0]     out_stream,
   output logic [PARITY_WIDTH-1:0] out_rem
);

   // top stream bit handled by this stage
   localparam int BASE = STREAM_W - 1 - STAGE_IDX * STEPS;

   logic [PARITY_WIDTH-1:0] rem_in;
   logic [PARITY_WIDTH-1:0] rem_ff;
   logic [STREAM_W-1:0]     stream_ff;
   logic                    valid_ff;

   // chain of division steps over this stage's slice of the stream
   always_comb begin
      logic                    tap;
      logic [PARITY_WIDTH-1:0] r;
      r = in_rem;
      for (int k = 0; k < STEPS; k++) begin
         tap = |(r & tap_vec);
         r   = ({r[PARITY_WIDTH-2:0], in_stream[BASE - k]} & mask) ^
               (tap ? poly : {PARITY_WIDTH{1'b0}});
      end
      rem_in = r;
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff    <= rem_in;
         stream_ff <= in_stream;
      end
   end

   assign out_valid  = valid_ff;
   assign out_stream = stream_ff;
   assign out_rem    = rem_ff;

endmodule

FILE: hdl/bch_parity_generator_top.sv
// ----------------------------------------------------------------------------
// bch_parity_generator_top
// systematic bch parity of a message word over a programmable generator
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_message, req_bit_count
//   rsp      out        rsp_valid/stall    rsp_parity
//   csr      in         csr_valid/ready    csr_index, csr_wdata
//
// one request is taken every cycle while no result is stalled; a result passes
// through a front stage, one stage per eight division steps over
// MSG_WIDTH + 31 stream bits, and the output register.
// reset clears the valid bits and loads the beacon code into the registers.
// a stalled result freezes the whole pipeline, and req_stall follows it.
// ----------------------------------------------------------------------------
module bch_parity_generator_top #(
   parameter int MSG_WIDTH    = bchpg_pkg::MSG_WIDTH_DEF,
   parameter int PARITY_WIDTH = bchpg_pkg::PARITY_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [MSG_WIDTH-1:0]               req_message,
   input  logic [bchpg_pkg::COUNT_W-1:0]      req_bit_count,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [PARITY_WIDTH-1:0]            rsp_parity,
   // configuration channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bchpg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bchpg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RAW_W      = MSG_WIDTH + bchpg_pkg::MAX_DEGREE;
   localparam int STEPS      = bchpg_pkg::STEPS_PER_STAGE;
   localparam int NUM_STAGES = (RAW_W + STEPS - 1) / STEPS;
   localparam int STREAM_W   = NUM_STAGES * STEPS;

   // configuration registers
   logic [bchpg_pkg::CSR_DATA_W-1:0] gen_poly_ff, gen_poly_in;
   logic [bchpg_pkg::DEGREE_W-1:0]   degree_ff, degree_in;
   logic [bchpg_pkg::CSR_DATA_W-1:0] rem_mask_ff, rem_mask_in;

   // effective division terms
   logic [PARITY_WIDTH-1:0] poly_eff;
   logic [PARITY_WIDTH-1:0] mask_eff;
   logic [PARITY_WIDTH-1:0] tap_vec;
   logic                    zero_degree;

   // pipeline
   logic                    advance;
   logic                    stg_valid [NUM_STAGES+1];
   logic [STREAM_W-1:0]     stg_stream[NUM_STAGES+1];
   logic [PARITY_WIDTH-1:0] stg_rem   [NUM_STAGES+1];

   // output register
   logic                    rsp_valid_ff;
   logic [PARITY_WIDTH-1:0] parity_ff, parity_in;

   // register write decode
   assign csr_ready = 1'b1;

   always_comb begin
      gen_poly_in = gen_poly_ff;
      degree_in   = degree_ff;
      rem_mask_in = rem_mask_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bchpg_pkg::CSR_GEN_POLY: gen_poly_in = csr_wdata;
            bchpg_pkg::CSR_DEGREE:   degree_in   = csr_wdata[bchpg_pkg::DEGREE_W-1:0];
            bchpg_pkg::CSR_REM_MASK: rem_mask_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_poly_ff <= bchpg_pkg::GEN_POLY_RST;
         degree_ff   <= bchpg_pkg::DEGREE_RST;
         rem_mask_ff <= bchpg_pkg::REM_MASK_RST;
      end else begin
         gen_poly_ff <= gen_poly_in;
         degree_ff   <= degree_in;
         rem_mask_ff <= rem_mask_in;
      end
   end

   // generator cut to degree + 1 bits, tap one-hot at bit degree - 1
   always_comb begin
      for (int b = 0; b < PARITY_WIDTH; b++) begin
         poly_eff[b] = gen_poly_ff[b] &
                       ((bchpg_pkg::DEGREE_W+1)'(b) <= {1'b0, degree_ff});
         tap_vec[b]  = ((bchpg_pkg::DEGREE_W+1)'(b + 1) == {1'b0, degree_ff});
      end
   end

   assign mask_eff    = rem_mask_ff[PARITY_WIDTH-1:0];
   assign zero_degree = (degree_ff == '0);

   // whole pipeline holds while a result waits
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // front stage
   bchpg_prep #(
      .MSG_WIDTH (MSG_WIDTH),
      .STREAM_W  (STREAM_W)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .message      (req_message),
      .bit_count    (req_bit_count),
      .degree       (degree_ff),
      .out_valid    (stg_valid[0]),
      .out_stream   (stg_stream[0])
   );

   assign stg_rem[0] = '0;

   // division stages
   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      bchpg_stage #(
         .PARITY_WIDTH (PARITY_WIDTH),
         .STREAM_W     (STREAM_W),
         .STAGE_IDX    (s),
         .STEPS        (STEPS)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .in_valid   (stg_valid[s]),
         .in_stream  (stg_stream[s]),
         .in_rem     (stg_rem[s]),
         .poly       (poly_eff),
         .mask       (mask_eff),
         .tap_vec    (tap_vec),
         .out_valid  (stg_valid[s+1]),
         .out_stream (stg_stream[s+1]),
         .out_rem    (stg_rem[s+1])
      );
   end

   // final mask and output register
   assign parity_in = zero_degree ? '0 : (stg_rem[NUM_STAGES] & mask_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stg_valid[NUM_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         parity_ff <= parity_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_parity = parity_ff;

endmodule

FILE: hdl/bchpg_checker.sv
// ----------------------------------------------------------------------------
// bchpg_port_checks
// port-level checks of the bch parity generator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bchpg_port_checks #(
   parameter int PARITY_WIDTH = bchpg_pkg::PARITY_WIDTH_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [PARITY_WIDTH-1:0] rsp_parity
);

   // a waiting result stays put
   `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_parity), "result changed while stalled")

   // requests are held back only by a stalled result
   `ASSERT_CLK(a_stall_cause, req_stall |-> rsp_valid && rsp_stall, "request stalled without a waiting result")

   // a stalled result always stops new requests
   `ASSERT_CLK(a_stall_back, rsp_valid && rsp_stall |-> req_stall, "request taken while the pipeline is frozen")

   // reset empties the pipeline
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind bch_parity_generator_top bchpg_port_checks #(.PARITY_WIDTH(PARITY_WIDTH)) u_port_checks (.*);

FILE: dv/bchpg_checker.sv
// ----------------------------------------------------------------------------
// bchpg_checker
// watches the request, result and register channels of the bch parity
// generator, works out the parity of every accepted request from its own
// copy of the generator registers and compares it with the returned result
// ----------------------------------------------------------------------------
module bchpg_checker #(
   parameter int MSG_WIDTH    = bchpg_pkg::MSG_WIDTH_DEF,
   parameter int PARITY_WIDTH = bchpg_pkg::PARITY_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [MSG_WIDTH-1:0]                req_message,
   input  logic [bchpg_pkg::COUNT_W-1:0]       req_bit_count,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [PARITY_WIDTH-1:0]             rsp_parity,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [bchpg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bchpg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                  fail_count,
   output int                                  outstanding,
   output int                                  results_checked
);

   localparam logic [63:0] PARITY_KEEP = (64'd1 << PARITY_WIDTH) - 64'd1;

   // local copy of the generator registers
   logic [bchpg_pkg::CSR_DATA_W-1:0] gen_poly_q;
   logic [bchpg_pkg::DEGREE_W-1:0]   degree_q;
   logic [bchpg_pkg::CSR_DATA_W-1:0] rem_mask_q;

   // parities still owed by the block, oldest first
   logic [PARITY_WIDTH-1:0] parity_due_q[$];

   // long division of the used message bits followed by degree zero bits
   function automatic logic [PARITY_WIDTH-1:0] bch_remainder(
      input logic [MSG_WIDTH-1:0]              msg,
      input logic [bchpg_pkg::COUNT_W-1:0]     nbits
   );
      logic [63:0] rem;
      logic [63:0] poly;
      logic [63:0] keep;
      logic        feedback;
      logic        din;
      int          used;
      int          deg;
      deg = int'(degree_q);
      if (deg == 0) return '0;
      used = (int'(nbits) > MSG_WIDTH) ? MSG_WIDTH : int'(nbits);
      keep = 64'(rem_mask_q) & PARITY_KEEP;
      poly = 64'(gen_poly_q) & ((64'd1 << (deg + 1)) - 64'd1) & PARITY_KEEP;
      rem  = '0;
      for (int k = 0; k < used + deg; k++) begin
         din      = (k < used) ? msg[used - 1 - k] : 1'b0;
         feedback = rem[deg - 1];
         rem      = ((rem << 1) | 64'(din)) & keep;
         if (feedback) rem = rem ^ poly;
         rem = rem & 64'h0000_0000_FFFF_FFFF;
      end
      return PARITY_WIDTH'(rem & keep);
   endfunction

   always @(posedge clock) begin
      logic [PARITY_WIDTH-1:0] due;
      if (reset) begin
         gen_poly_q = bchpg_pkg::GEN_POLY_RST;
         degree_q   = bchpg_pkg::DEGREE_RST;
         rem_mask_q = bchpg_pkg::REM_MASK_RST;
         fail_count      = 0;
         results_checked = 0;
         parity_due_q.delete();
      end else begin
         // register writes, unknown indexes fall through untouched
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bchpg_pkg::CSR_GEN_POLY: gen_poly_q = csr_wdata;
               bchpg_pkg::CSR_DEGREE:   degree_q   = csr_wdata[bchpg_pkg::DEGREE_W-1:0];
               bchpg_pkg::CSR_REM_MASK: rem_mask_q = csr_wdata;
               default: ;
            endcase
         end
         // compare each accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (parity_due_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual parity %h",
                        $time, rsp_parity);
            end else begin
               due = parity_due_q.pop_front();
               if (rsp_parity !== due) begin
                  fail_count++;
                  $display("%0t: parity wrong, expected %h, actual %h",
                           $time, due, rsp_parity);
               end
            end
         end
         // predict each accepted request
         if (req_valid && !req_stall)
            parity_due_q.push_back(bch_remainder(req_message, req_bit_count));
      end
      outstanding <= parity_due_q.size();
   end

endmodule

FILE: dv/tb_bch_parity_generator_top.sv
// ----------------------------------------------------------------------------
// tb_bch_parity_generator_top
// drives requests and register writes into the bch parity generator across
// a range of generator settings, with random gaps and result back-pressure,
// and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_bch_parity_generator_top;

   localparam int MSG_WIDTH    = bchpg_pkg::MSG_WIDTH_DEF;
   localparam int PARITY_WIDTH = bchpg_pkg::PARITY_WIDTH_DEF;
   localparam int ITEMS_PER_SETTING = 45;
   localparam int LONG_HOLD_CYCLES  = 80;
   localparam int PIPE_SETTLE       = 30;
   localparam logic [bchpg_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [MSG_WIDTH-1:0]                req_message = '0;
   logic [bchpg_pkg::COUNT_W-1:0]       req_bit_count = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [PARITY_WIDTH-1:0]             rsp_parity;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [bchpg_pkg::CSR_INDEX_W-1:0]   csr_index = bchpg_pkg::CSR_GEN_POLY;
   logic [bchpg_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   int fail_count;
   int outstanding;
   int results_checked;
   int settings_run = 0;

   // shared pacing controls
   logic burst_mode = 1'b0;
   int   long_hold_asked = 0;

   always #5 clock = ~clock;

   bch_parity_generator_top #(
      .MSG_WIDTH   (MSG_WIDTH),
      .PARITY_WIDTH(PARITY_WIDTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_message     (req_message),
      .req_bit_count   (req_bit_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_parity      (rsp_parity),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   bchpg_checker #(
      .MSG_WIDTH   (MSG_WIDTH),
      .PARITY_WIDTH(PARITY_WIDTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_message     (req_message),
      .req_bit_count   (req_bit_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_parity      (rsp_parity),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   function automatic int draw_gap();
      return burst_mode ? 0 : $urandom_range(0, 15);
   endfunction

   // offer one request after a random gap, return at the accepting edge
   task automatic send_request(input logic [MSG_WIDTH-1:0] msg,
                               input logic [bchpg_pkg::COUNT_W-1:0] nbits);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_message   <= msg;
      req_bit_count <= nbits;
      do @(posedge clock); while (req_stall);
   endtask

   // random requests, mostly in-range counts with some zero and oversize ones
   task automatic send_random(input int n);
      logic [MSG_WIDTH-1:0]            msg;
      logic [bchpg_pkg::COUNT_W-1:0]   nbits;
      int                              shape;
      for (int i = 0; i < n; i++) begin
         shape = $urandom_range(0, 9);
         msg   = {$urandom, $urandom};
         nbits = bchpg_pkg::COUNT_W'($urandom_range(1, MSG_WIDTH));
         if (shape == 0)
            nbits = bchpg_pkg::COUNT_W'($urandom_range(0, (1 << bchpg_pkg::COUNT_W) - 1));
         else if (shape == 1)
            msg = MSG_WIDTH'(1) << $urandom_range(0, MSG_WIDTH - 1);
         send_request(msg, nbits);
      end
   endtask

   // one register write, csr_valid left high for a following write
   task automatic write_reg(input logic [bchpg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [bchpg_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input logic [bchpg_pkg::CSR_DATA_W-1:0] poly,
                                input logic [bchpg_pkg::DEGREE_W-1:0] deg,
                                input logic [bchpg_pkg::CSR_DATA_W-1:0] keep);
      write_reg(bchpg_pkg::CSR_GEN_POLY, poly);
      write_reg(bchpg_pkg::CSR_DEGREE, bchpg_pkg::CSR_DATA_W'(deg));
      write_reg(bchpg_pkg::CSR_REM_MASK, keep);
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   // stop offering and let every owed result come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // result side: random stall before each result, one long hold on request
   initial begin
      int hold;
      int long_hold_given;
      long_hold_given = 0;
      do @(posedge clock); while (reset);
      forever begin
         hold = draw_gap();
         if (long_hold_asked > long_hold_given) begin
            hold = LONG_HOLD_CYCLES;
            long_hold_given++;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset code: field extremes and the count corner cases
      settings_run++;
      send_request('0, 7'd64);
      send_request('1, 7'd64);
      send_request('1, 7'd0);
      send_request(64'd1, 7'd1);
      send_request(64'd0, 7'd1);
      send_request('1, 7'd127);
      send_request('1, 7'd65);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 7'd64);
      send_request(64'h5555_5555_5555_5555, 7'd64);
      send_request(64'h8000_0000_0000_0000, 7'd64);
      send_request(64'h8000_0000_0000_0000, 7'd63);
      send_request(64'hFFFF_FFFF_FFFF_FF5A, 7'd8);
      send_request({$urandom, $urandom}, 7'd32);
      send_request(64'h0000_0000_0012_3456, 7'd21);
      send_random(ITEMS_PER_SETTING);
      drain();

      // widest generator, everything set
      apply_setting('1, 5'd31, '1);
      send_request('1, 7'd64);
      send_request(64'd1, 7'd1);
      send_random(ITEMS_PER_SETTING);
      drain();

      // smallest generator, no gaps on either side
      burst_mode = 1'b1;
      apply_setting(32'h0000_0003, 5'd1, 32'h0000_0001);
      send_request('1, 7'd64);
      send_random(ITEMS_PER_SETTING);
      drain();
      burst_mode = 1'b0;

      // degree zero gives no parity at all
      apply_setting($urandom, 5'd0, $urandom);
      send_random(ITEMS_PER_SETTING);
      drain();

      // crc16, with a long result hold while requests keep coming
      apply_setting(32'h0001_1021, 5'd16, 32'h0000_FFFF);
      long_hold_asked++;
      burst_mode = 1'b1;
      send_random(40);
      burst_mode = 1'b0;
      send_random(ITEMS_PER_SETTING - 40);
      drain();

      // mask wider than the degree lets the stray top bit through
      apply_setting(32'h0001_1021, 5'd16, '1);
      send_random(ITEMS_PER_SETTING);
      drain();

      // arbitrary mask over a random generator
      burst_mode = 1'b1;
      apply_setting($urandom, 5'd8, $urandom);
      send_random(ITEMS_PER_SETTING);
      drain();
      burst_mode = 1'b0;

      // all-zero generator
      apply_setting('0, 5'd12, 32'h0000_0FFF);
      send_random(ITEMS_PER_SETTING);
      drain();

      // fully random setting, then a write to an unused index that must not land
      apply_setting($urandom,
                    bchpg_pkg::DEGREE_W'($urandom_range(1, bchpg_pkg::MAX_DEGREE)),
                    $urandom);
      write_reg(CSR_SPARE, $urandom);
      csr_valid <= 1'b0;
      send_random(ITEMS_PER_SETTING);
      drain();

      $display("run covered %0d generator settings including degree zero and odd masks,",
               settings_run);
      $display("with %0d parity results checked under random gaps and back-pressure",
               results_checked);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
